/* hdl/oidb_pkg.sv */
package oidb_pkg;

    localparam int DEF_MAX_SUBIDS = 32;
    localparam int GROUP_BYTES    = 5;
    localparam int FIRST_DIV      = 40;
    localparam int RBUF_DEPTH     = 4;

    localparam logic [7:0] LOW7     = 8'h7F;
    localparam logic [7:0] CONT_BIT = 8'h80;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LONG  = 2'd1,
        ST_TRUNCATED = 2'd2,
        ST_TOO_MANY  = 2'd3
    } t_status;

    typedef struct packed {
        logic [31:0] value;
        logic        final_item;
        t_status     status;
    } t_result;

    // results produced by one accepted byte: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

    // byte / 40 as (byte / 8) / 5, with x / 5 = (x * 13) >> 6 for x < 32
    function automatic logic [2:0] div_first(input logic [7:0] b);
        logic [8:0] prod;
        prod = 9'(b[7:3]) * 9'd13;
        return prod[8:6];
    endfunction

    function automatic logic [7:0] mod_first(input logic [7:0] b);
        logic [2:0] q;
        logic [7:0] qx;
        q  = div_first(b);
        qx = 8'({q, 5'b0}) + 8'({q, 3'b0});
        return b - qx;
    endfunction

endpackage

/* hdl/oidb_core.sv */
module oidb_core #(
    parameter int MAX_SUBIDS = oidb_pkg::DEF_MAX_SUBIDS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  logic [7:0]     i_data_byte,
    input  logic           i_end_of_string,
    output oidb_pkg::t_push o_push
);
    import oidb_pkg::*;

    localparam logic [7:0] LEN_LIMIT = 8'(MAX_SUBIDS * GROUP_BYTES);
    localparam logic [5:0] CNT_LIMIT = 6'(MAX_SUBIDS);

    logic        r_expect_first, n_expect_first;
    logic [31:0] r_acc, n_acc;
    logic        r_mid_subid, n_mid_subid;
    logic [7:0]  r_byte_count, n_byte_count;
    logic [5:0]  r_subid_count, n_subid_count;
    logic        r_dropping, n_dropping;

    logic [31:0] acc_shift;
    t_push       push;

    assign acc_shift = {r_acc[24:0], i_data_byte[6:0] & LOW7[6:0]};

    always_comb begin
        n_expect_first = r_expect_first;
        n_acc          = r_acc;
        n_mid_subid    = r_mid_subid;
        n_byte_count   = r_byte_count;
        n_subid_count  = r_subid_count;
        n_dropping     = r_dropping;
        push.count     = 2'd0;
        push.r0        = '{value: 32'd0, final_item: 1'b1, status: ST_OK};
        push.r1        = '{value: 32'd0, final_item: 1'b0, status: ST_OK};

        if (r_dropping) begin
            if (i_end_of_string) begin
                n_dropping = 1'b0;
            end
        end else if (r_byte_count >= LEN_LIMIT) begin
            push.count     = 2'd1;
            push.r0.status = ST_TOO_LONG;
            n_dropping     = !i_end_of_string;
        end else if (r_expect_first) begin
            n_byte_count       = r_byte_count + 8'd1;
            push.count         = 2'd2;
            push.r0.value      = 32'(div_first(i_data_byte));
            push.r0.final_item = 1'b0;
            push.r1.value      = 32'(mod_first(i_data_byte));
            push.r1.final_item = i_end_of_string;
            n_expect_first     = 1'b0;
            n_subid_count      = 6'd2;
        end else begin
            n_byte_count = r_byte_count + 8'd1;
            n_acc        = acc_shift;
            if ((i_data_byte & CONT_BIT) != 8'd0) begin
                n_mid_subid = 1'b1;
                if (i_end_of_string) begin
                    push.count     = 2'd1;
                    push.r0.status = ST_TRUNCATED;
                end
            end else if (r_subid_count >= CNT_LIMIT) begin
                push.count     = 2'd1;
                push.r0.status = ST_TOO_MANY;
                n_dropping     = !i_end_of_string;
            end else begin
                push.count         = 2'd1;
                push.r0.value      = acc_shift;
                push.r0.final_item = i_end_of_string;
                n_subid_count      = r_subid_count + 6'd1;
                n_acc              = 32'd0;
                n_mid_subid        = 1'b0;
            end
        end

        // end of string always returns the decoder to its idle state
        if (i_end_of_string) begin
            n_expect_first = 1'b1;
            n_acc          = 32'd0;
            n_mid_subid    = 1'b0;
            n_byte_count   = 8'd0;
            n_subid_count  = 6'd0;
            n_dropping     = 1'b0;
        end

        if (!i_take) begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_first <= 1'b1;
            r_acc          <= 32'd0;
            r_mid_subid    <= 1'b0;
            r_byte_count   <= 8'd0;
            r_subid_count  <= 6'd0;
            r_dropping     <= 1'b0;
        end else if (i_take) begin
            r_expect_first <= n_expect_first;
            r_acc          <= n_acc;
            r_mid_subid    <= n_mid_subid;
            r_byte_count   <= n_byte_count;
            r_subid_count  <= n_subid_count;
            r_dropping     <= n_dropping;
        end
    end

    assign o_push = push;

endmodule

/* hdl/oidb_rbuf.sv */
module oidb_rbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  oidb_pkg::t_push   i_push,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output oidb_pkg::t_result o_result
);
    import oidb_pkg::*;

    localparam int PW = $clog2(RBUF_DEPTH);
    localparam int CW = $clog2(RBUF_DEPTH + 1);

    t_result        r_mem [RBUF_DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic [PW-1:0]  wr_ptr1;
    logic           pop;

    assign pop     = (r_count != '0) && !i_stall;
    assign wr_ptr1 = r_wr_ptr + PW'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + PW'(i_push.count);
        n_rd_ptr = r_rd_ptr + PW'(pop);
        n_count  = r_count + CW'(i_push.count) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.r1;
        end
    end

    // keep room for the two results a first byte can produce
    assign o_full   = r_count > CW'(RBUF_DEPTH - 2);
    assign o_valid  = r_count != '0;
    assign o_result = r_mem[r_rd_ptr];

endmodule

/* hdl/oid_base128_decoder.sv */
// channel | valid   | stall   | payload
// --------+---------+---------+----------------------------------------------
// in      | i_valid | o_stall | i_data_byte, i_end_of_string
// out     | o_valid | i_stall | o_subid_value, o_final_item, o_status
//
// One byte is accepted per cycle while o_stall is low; its results are
// written into a four-entry result buffer and reach the output once the
// results ahead of them have drained. The first byte of a string yields
// two results, drained one per cycle while i_stall is low. o_stall is high
// while the buffer holds more than two results. Reset (synchronous, active
// low) readies the decoder for a new string and empties the buffer.
module oid_base128_decoder #(
    parameter int MAX_SUBIDS = oidb_pkg::DEF_MAX_SUBIDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_string,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_subid_value,
    output logic        o_final_item,
    output logic [1:0]  o_status
);
    import oidb_pkg::*;

    logic    take;
    logic    full;
    t_push   push;
    t_result result;

    assign take    = i_valid && !full;
    assign o_stall = full;

    oidb_core #(
        .MAX_SUBIDS (MAX_SUBIDS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_data_byte     (i_data_byte),
        .i_end_of_string (i_end_of_string),
        .o_push          (push)
    );

    oidb_rbuf u_rbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (result)
    );

    assign o_subid_value = result.value;
    assign o_final_item  = result.final_item;
    assign o_status      = result.status;

endmodule

/* bench/testbench.sv */
module testbench;
    import oidb_pkg::*;

    localparam int MAX_SUB      = DEF_MAX_SUBIDS;
    localparam int LENGTH_CAP   = MAX_SUB * GROUP_BYTES;
    localparam int RANDOM_ITEMS = 1450;
    localparam int CYCLE_LIMIT  = 200000;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte     = 8'h00;
    logic        i_end_of_string = 1'b0;
    logic        o_valid;
    logic        i_stall         = 1'b0;
    logic [31:0] o_subid_value;
    logic        o_final_item;
    logic [1:0]  o_status;

    oid_base128_decoder #(
        .MAX_SUBIDS(MAX_SUB)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_string (i_end_of_string),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_subid_value   (o_subid_value),
        .o_final_item    (o_final_item),
        .o_status        (o_status)
    );

    // decoder state as the testbench sees it
    logic        awaiting_first = 1'b1;
    logic [31:0] partial_subid  = '0;
    logic        in_subid       = 1'b0;
    logic [7:0]  string_len     = '0;
    logic [5:0]  subids_done    = '0;
    logic        discarding     = 1'b0;

    t_result     pending_subids[$];
    logic [7:0]  enc_bytes[$];

    int tx_idle_pct     = 17;
    int rx_idle_pct     = 17;
    int hold_cycles     = 0;
    int fault_count     = 0;
    int bytes_decoded   = 0;
    int strings_sent    = 0;
    int results_checked = 0;
    int error_reports   = 0;
    int input_held      = 0;
    int cycle_count     = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still outstanding", $time,
                     pending_subids.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random stall, or a counted hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_checked++;
            if (pending_subids.size() == 0) begin
                fault_count++;
                $display("%0t: unexpected result: value %0d final %0d status %0d",
                         $time, o_subid_value, o_final_item, o_status);
            end else begin
                want = pending_subids.pop_front();
                if (o_subid_value !== want.value) begin
                    fault_count++;
                    $display("%0t: subid_value expected %0d, got %0d",
                             $time, want.value, o_subid_value);
                end
                if (o_final_item !== want.final_item) begin
                    fault_count++;
                    $display("%0t: final_item expected %0d, got %0d",
                             $time, want.final_item, o_final_item);
                end
                if (o_status !== want.status) begin
                    fault_count++;
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, o_status);
                end
            end
        end
    end

    function void add_result(logic [31:0] value, logic last, t_status st);
        t_result r;
        r.value      = value;
        r.final_item = last;
        r.status     = st;
        pending_subids.push_back(r);
        if (st != ST_OK)
            error_reports++;
    endfunction

    function void restart_string();
        awaiting_first = 1'b1;
        partial_subid  = '0;
        in_subid       = 1'b0;
        string_len     = '0;
        subids_done    = '0;
        discarding     = 1'b0;
    endfunction

    function void report_error(t_status st, logic eos);
        add_result('0, 1'b1, st);
        if (eos)
            restart_string();
        else
            discarding = 1'b1;
    endfunction

    function void predict_subids(logic [7:0] b, logic eos);
        if (discarding) begin
            if (eos)
                restart_string();
            return;
        end
        bytes_decoded++;
        // length is checked before the byte is looked at
        if (string_len >= LENGTH_CAP) begin
            report_error(ST_TOO_LONG, eos);
            return;
        end
        string_len++;
        if (awaiting_first) begin
            add_result(32'(b / FIRST_DIV), 1'b0, ST_OK);
            add_result(32'(b % FIRST_DIV), eos, ST_OK);
            awaiting_first = 1'b0;
            subids_done    = 6'd2;
            if (eos)
                restart_string();
            return;
        end
        partial_subid = {partial_subid[24:0], 7'(b & LOW7)};
        if ((b & CONT_BIT) != 0) begin
            in_subid = 1'b1;
            if (eos)
                report_error(ST_TRUNCATED, eos);
            return;
        end
        if (subids_done >= MAX_SUB) begin
            report_error(ST_TOO_MANY, eos);
            return;
        end
        add_result(partial_subid, eos, ST_OK);
        subids_done++;
        partial_subid = '0;
        in_subid      = 1'b0;
        if (eos)
            restart_string();
    endfunction

    // one input transaction; valid stays up until the decoder takes it
    task send_byte(input logic [7:0] b, input logic eos);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_data_byte     <= b;
        i_end_of_string <= eos;
        @(posedge i_clk);
        while (o_stall) begin
            input_held++;
            @(posedge i_clk);
        end
        predict_subids(b, eos);
    endtask

    task send_oid();
        for (int k = 0; k < enc_bytes.size(); k++)
            send_byte(enc_bytes[k], k == enc_bytes.size() - 1);
        strings_sent++;
    endtask

    task drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_subids.size() != 0)
            @(posedge i_clk);
        repeat (RBUF_DEPTH + 2) @(posedge i_clk);
    endtask

    function int pick_groups();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 1;
        if (r < 85)
            return 2;
        if (r < 97)
            return $urandom_range(5, 3);
        return 6;
    endfunction

    // random sub-identifier, most significant group first
    function void put_subid(int groups);
        for (int g = groups - 1; g >= 0; g--)
            enc_bytes.push_back(8'($urandom_range(127)) | ((g > 0) ? CONT_BIT : 8'h00));
    endfunction

    function void put_first();
        enc_bytes.delete();
        enc_bytes.push_back(8'($urandom_range(255)));
    endfunction

    task test_first_byte();
        logic [7:0] firsts[8];
        firsts = '{8'd0, 8'd39, 8'd40, 8'd79, 8'd80, 8'd119, 8'd120, 8'd255};
        foreach (firsts[k]) begin
            enc_bytes = '{firsts[k]};
            send_oid();
        end
        drain();
    endtask

    task test_multibyte();
        // 128, all ones, then a value that overflows the accumulator
        enc_bytes = '{8'h2B, 8'h81, 8'h00, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                      8'h81, 8'h80, 8'h80, 8'h80, 8'h80, 8'h01};
        send_oid();
        drain();
    endtask

    task test_truncated();
        enc_bytes = '{8'h2B, 8'h86};
        send_oid();
        enc_bytes = '{8'h2B, 8'h01, 8'hFF};
        send_oid();
        drain();
    endtask

    task test_too_many();
        put_first();
        repeat (MAX_SUB - 2) put_subid(1);
        put_subid(2);
        repeat (3) enc_bytes.push_back(8'($urandom_range(255)));
        send_oid();
        // error on the closing byte: nothing gets dropped afterwards
        put_first();
        repeat (MAX_SUB - 1) put_subid(1);
        send_oid();
        enc_bytes = '{8'h2A, 8'h03};
        send_oid();
        drain();
    endtask

    task test_too_long();
        put_first();
        repeat (LENGTH_CAP - 1) enc_bytes.push_back(CONT_BIT | 8'($urandom_range(127)));
        repeat (3) enc_bytes.push_back(8'($urandom_range(255)));
        send_oid();
        put_first();
        repeat (LENGTH_CAP - 1) enc_bytes.push_back(CONT_BIT | 8'($urandom_range(127)));
        enc_bytes.push_back(8'($urandom_range(255)));
        send_oid();
        enc_bytes = '{8'h51, 8'h7F};
        send_oid();
        drain();
    endtask

    task test_pressure();
        tx_idle_pct = 0;
        hold_cycles = 80;
        repeat (40) begin
            put_first();
            send_oid();
        end
        tx_idle_pct = 17;
        drain();
    endtask

    task test_random();
        int kind;
        int base;
        int done;
        int n;
        base = bytes_decoded;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            if (done >= 700 && done < 1000) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = 17;
                rx_idle_pct = 17;
            end
            kind = $urandom_range(999);
            put_first();
            if (kind < 720) begin
                repeat ($urandom_range(6)) put_subid(pick_groups());
                send_oid();
            end else if (kind < 820) begin
                // ends inside a sub-identifier
                repeat ($urandom_range(3)) put_subid(pick_groups());
                repeat ($urandom_range(4, 1))
                    enc_bytes.push_back(CONT_BIT | 8'($urandom_range(127)));
                send_oid();
            end else if (kind < 870) begin
                // right at the sub-identifier limit or past it
                repeat (MAX_SUB - 2 + $urandom_range(2)) put_subid($urandom_range(2, 1));
                repeat ($urandom_range(3)) enc_bytes.push_back(8'($urandom_range(255)));
                send_oid();
            end else if (kind < 873) begin
                repeat (LENGTH_CAP - 2 + $urandom_range(3))
                    enc_bytes.push_back(CONT_BIT | 8'($urandom_range(127)));
                enc_bytes.push_back(8'($urandom_range(127)));
                send_oid();
            end else begin
                // raw bytes with end marks anywhere
                n = $urandom_range(10, 1);
                repeat (n) send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
                send_byte(8'($urandom_range(255)), 1'b1);
                strings_sent++;
            end
            done = bytes_decoded - base;
        end
        tx_idle_pct = 17;
        rx_idle_pct = 17;
        drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_first_byte();
        test_multibyte();
        test_truncated();
        test_too_many();
        test_too_long();
        test_pressure();
        test_random();
        $display("Decoded %0d bytes over %0d strings; %0d results checked, %0d error reports.",
                 bytes_decoded, strings_sent, results_checked, error_reports);
        $display("Input was held off by a full result buffer for %0d cycles.", input_held);
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
hdl/oidb_pkg.sv
hdl/oidb_core.sv
hdl/oidb_rbuf.sv
hdl/oid_base128_decoder.sv
bench/testbench.sv
